// ----- rtl/core/bwts_pkg.sv -----
// ----------------------------------------------------------------------------
// bwts_pkg
// Shared types, codes and helpers of the bilinear wrap texture sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package bwts_pkg;

	localparam int COORD_W = 18;
	localparam int SZ_W    = 9;
	localparam int CH_W    = 8;
	localparam int NUM_CH  = 4;
	localparam int PIX_W   = CH_W * NUM_CH;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;
	localparam int PH_W    = 3;

	typedef logic [PIX_W-1:0] pixel_t;
	typedef logic [SZ_W-1:0]  size_t;
	typedef logic [PH_W-1:0]  phase_t;

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam phase_t PH_P00  = 3'd0;
	localparam phase_t PH_P10  = 3'd1;
	localparam phase_t PH_P01  = 3'd2;
	localparam phase_t PH_P11  = 3'd3;
	localparam phase_t PH_LAST = 3'd4;

	function automatic size_t mod_step(input size_t rem, input logic bit_in, input size_t d);
		logic [SZ_W:0] tmp;
		begin
			tmp = {rem, bit_in};
			if (tmp >= {1'b0, d}) begin
				tmp = tmp - {1'b0, d};
			end
			return tmp[SZ_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bilinear_wrap_texture_sampler.sv -----
// Throughput: one write per cycle while out_ready holds no stall; the single
// pixel memory port serves the four neighbour reads of a sample one per cycle,
// and later items wait until the sample leaves the fetch stage.
// Reset clears all pipeline control and sets width and height to 256; the
// pixel memory is not cleared and holds undefined data until written.
// ----------------------------------------------------------------------------
// bilinear_wrap_texture_sampler
// RGBA pixel store with write and bilinear sample transactions, repeat wrap.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_wrap_texture_sampler #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [bwts_pkg::APB_AW-1:0]          paddr,
	input  wire logic [bwts_pkg::APB_DW-1:0]          pwdata,
	output logic      [bwts_pkg::APB_DW-1:0]          prdata,
	output logic                                     pready,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                command,
	input  wire logic signed [bwts_pkg::COORD_W-1:0] coord_x,
	input  wire logic signed [bwts_pkg::COORD_W-1:0] coord_y,
	input  wire logic [bwts_pkg::CH_W-1:0]           write_red,
	input  wire logic [bwts_pkg::CH_W-1:0]           write_green,
	input  wire logic [bwts_pkg::CH_W-1:0]           write_blue,
	input  wire logic [bwts_pkg::CH_W-1:0]           write_alpha,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [bwts_pkg::CH_W-1:0]                out_red,
	output logic [bwts_pkg::CH_W-1:0]                out_green,
	output logic [bwts_pkg::CH_W-1:0]                out_blue,
	output logic [bwts_pkg::CH_W-1:0]                out_alpha,
	output logic                                     was_sample
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = bwts_pkg::COORD_W - FRAC_BITS;
	localparam int H1    = (IW + 1) / 2;
	localparam int H2    = IW - H1;
	localparam int LW    = FRAC_BITS + 10;
	localparam int CW    = bwts_pkg::COORD_W;
	localparam int SW    = bwts_pkg::SZ_W;
	localparam int NCH   = bwts_pkg::NUM_CH;
	localparam int CHW   = bwts_pkg::CH_W;

	function automatic logic [CHW-1:0] lerp8(input logic [CHW-1:0] a, input logic [CHW-1:0] b,
		input logic [FRAC_BITS-1:0] t);
		logic [FRAC_BITS:0] inv;
		logic [LW-1:0] acc;
		begin
			inv = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, t};
			acc = LW'(a) * LW'(inv) + LW'(b) * LW'(t);
			return acc[FRAC_BITS+CHW-1:FRAC_BITS];
		end
	endfunction

	function automatic logic [bwts_pkg::APB_DW-1:0] APB_DW_EXT(input bwts_pkg::size_t v);
		return {{(bwts_pkg::APB_DW-SW){1'b0}}, v};
	endfunction

	// Configuration registers.
	bwts_pkg::size_t width_q, height_q, eff_w, eff_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				bwts_pkg::REG_IMAGE_WIDTH:  width_q  <= pwdata[SW-1:0];
				bwts_pkg::REG_IMAGE_HEIGHT: height_q <= pwdata[SW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			bwts_pkg::REG_IMAGE_WIDTH:  prdata = APB_DW_EXT(width_q);
			bwts_pkg::REG_IMAGE_HEIGHT: prdata = APB_DW_EXT(height_q);
			default:                    prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	always_comb begin
		if (width_q == '0) begin
			eff_w = SW'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			eff_w = SW'(MAX_WIDTH);
		end else begin
			eff_w = width_q;
		end
		if (height_q == '0) begin
			eff_h = SW'(1);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			eff_h = SW'(MAX_HEIGHT);
		end else begin
			eff_h = height_q;
		end
	end

	// Pipeline control.
	logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
	logic take1, take2, take3, take4, take5, adv6, done3;
	bwts_pkg::phase_t phase_q;
	bwts_pkg::cmd_t cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5;

	assign adv6  = !v6_q || out_ready;
	assign take5 = !v5_q || adv6;
	assign take4 = !v4_q || (v4_q && take5);
	assign done3 = v3_q && ((cmd_s3 == bwts_pkg::CMD_WRITE) || (phase_q == bwts_pkg::PH_LAST));
	assign take3 = !v3_q || (done3 && take4);
	assign take2 = !v2_q || take3;
	assign take1 = !v1_q || take2;
	assign in_ready = take1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
			v3_q    <= 1'b0;
			v4_q    <= 1'b0;
			v5_q    <= 1'b0;
			v6_q    <= 1'b0;
			phase_q <= bwts_pkg::PH_P00;
		end else begin
			if (take1) v1_q <= in_valid;
			if (take2) v2_q <= v1_q;
			if (take3) v3_q <= v2_q;
			if (take4) v4_q <= done3;
			if (take5) v5_q <= v4_q;
			if (adv6)  v6_q <= v5_q;
			if (take3) begin
				phase_q <= bwts_pkg::PH_P00;
			end else if (v3_q && cmd_s3 == bwts_pkg::CMD_SAMPLE && phase_q != bwts_pkg::PH_LAST) begin
				phase_q <= phase_q + 3'd1;
			end
		end
	end

	// Stage 1: input register.
	logic signed [CW-1:0] cx_s1, cy_s1;
	bwts_pkg::pixel_t wdata_s1;

	always_ff @(posedge clk) begin
		if (take1) begin
			cmd_s1   <= bwts_pkg::cmd_t'(command);
			cx_s1    <= coord_x;
			cy_s1    <= coord_y;
			wdata_s1 <= {write_alpha, write_blue, write_green, write_red};
		end
	end

	// Stage 2: first half of the wrap remainder, write range check.
	logic [IW-1:0] ipx, ipy, magx, magy;
	bwts_pkg::size_t remx_c, remy_c;
	logic wr_ok_c;

	always_comb begin
		ipx  = cx_s1[CW-1:FRAC_BITS];
		ipy  = cy_s1[CW-1:FRAC_BITS];
		magx = cx_s1[CW-1] ? (~ipx + 1'b1) : ipx;
		magy = cy_s1[CW-1] ? (~ipy + 1'b1) : ipy;
		remx_c = '0;
		remy_c = '0;
		for (int i = 0; i < H1; i++) begin
			remx_c = bwts_pkg::mod_step(remx_c, magx[IW-1-i], eff_w);
			remy_c = bwts_pkg::mod_step(remy_c, magy[IW-1-i], eff_h);
		end
		wr_ok_c = !cx_s1[CW-1] && !cy_s1[CW-1]
			&& (cx_s1[CW-2:0] < (CW-1)'(eff_w)) && (cy_s1[CW-2:0] < (CW-1)'(eff_h));
	end

	bwts_pkg::size_t remx_s2, remy_s2, wcol_s2, wrow_s2;
	logic [IW-1:0] magx_s2, magy_s2;
	logic negx_s2, negy_s2, wr_ok_s2;
	logic [FRAC_BITS-1:0] tx_s2, ty_s2;
	bwts_pkg::pixel_t wdata_s2;

	always_ff @(posedge clk) begin
		if (take2) begin
			cmd_s2   <= cmd_s1;
			remx_s2  <= remx_c;
			remy_s2  <= remy_c;
			magx_s2  <= magx;
			magy_s2  <= magy;
			negx_s2  <= cx_s1[CW-1];
			negy_s2  <= cy_s1[CW-1];
			tx_s2    <= cx_s1[FRAC_BITS-1:0];
			ty_s2    <= cy_s1[FRAC_BITS-1:0];
			wr_ok_s2 <= wr_ok_c;
			wcol_s2  <= cx_s1[SW-1:0];
			wrow_s2  <= cy_s1[SW-1:0];
			wdata_s2 <= wdata_s1;
		end
	end

	// Stage 3 input: rest of the remainder, sign fix and right/lower neighbours.
	bwts_pkg::size_t rx, ry, x0_c, x1_c, y0_c, y1_c;

	always_comb begin
		rx = remx_s2;
		ry = remy_s2;
		for (int i = 0; i < H2; i++) begin
			rx = bwts_pkg::mod_step(rx, magx_s2[H2-1-i], eff_w);
			ry = bwts_pkg::mod_step(ry, magy_s2[H2-1-i], eff_h);
		end
		if (negx_s2 && rx != '0) rx = eff_w - rx;
		if (negy_s2 && ry != '0) ry = eff_h - ry;
		if (cmd_s2 == bwts_pkg::CMD_WRITE) begin
			x0_c = wcol_s2;
			y0_c = wrow_s2;
		end else begin
			x0_c = rx;
			y0_c = ry;
		end
		x1_c = (rx == eff_w - 1'b1) ? '0 : rx + 1'b1;
		y1_c = (ry == eff_h - 1'b1) ? '0 : ry + 1'b1;
	end

	// Stage 3: fetch unit on the pixel memory.
	bwts_pkg::size_t x0_s3, x1_s3, y0_s3, y1_s3, col, row;
	logic [FRAC_BITS-1:0] tx_s3, ty_s3;
	logic wr_ok_s3, mem_we, mem_re;
	bwts_pkg::pixel_t wdata_s3, rd_q;
	bwts_pkg::pixel_t slot_q [3];
	logic [AW-1:0] mem_addr;
	bwts_pkg::pixel_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (take3) begin
			cmd_s3   <= cmd_s2;
			x0_s3    <= x0_c;
			x1_s3    <= x1_c;
			y0_s3    <= y0_c;
			y1_s3    <= y1_c;
			tx_s3    <= tx_s2;
			ty_s3    <= ty_s2;
			wr_ok_s3 <= wr_ok_s2;
			wdata_s3 <= wdata_s2;
		end
		if (v3_q && cmd_s3 == bwts_pkg::CMD_SAMPLE) begin
			case (phase_q)
				bwts_pkg::PH_P10: slot_q[0] <= rd_q;
				bwts_pkg::PH_P01: slot_q[1] <= rd_q;
				bwts_pkg::PH_P11: slot_q[2] <= rd_q;
				default: ;
			endcase
		end
	end

	always_comb begin
		col = (phase_q == bwts_pkg::PH_P10 || phase_q == bwts_pkg::PH_P11) ? x1_s3 : x0_s3;
		row = (phase_q == bwts_pkg::PH_P01 || phase_q == bwts_pkg::PH_P11) ? y1_s3 : y0_s3;
		mem_addr = AW'(int'(row) * MAX_WIDTH + int'(col));
		mem_we = v3_q && cmd_s3 == bwts_pkg::CMD_WRITE && wr_ok_s3;
		mem_re = v3_q && cmd_s3 == bwts_pkg::CMD_SAMPLE && phase_q != bwts_pkg::PH_LAST;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= wdata_s3;
		if (mem_re) rd_q <= mem[mem_addr];
	end

	// Stage 4: four neighbours held for the horizontal lerps.
	bwts_pkg::pixel_t p_s4 [4];
	logic [FRAC_BITS-1:0] tx_s4, ty_s4, ty_s5;
	logic [CHW-1:0] top_s5 [NCH];
	logic [CHW-1:0] bot_s5 [NCH];

	always_ff @(posedge clk) begin
		if (take4) begin
			cmd_s4  <= cmd_s3;
			p_s4[0] <= slot_q[0];
			p_s4[1] <= slot_q[1];
			p_s4[2] <= slot_q[2];
			p_s4[3] <= rd_q;
			tx_s4   <= tx_s3;
			ty_s4   <= ty_s3;
		end
		if (take5) begin
			cmd_s5 <= cmd_s4;
			ty_s5  <= ty_s4;
			for (int k = 0; k < NCH; k++) begin
				top_s5[k] <= lerp8(p_s4[0][CHW*k +: CHW], p_s4[1][CHW*k +: CHW], tx_s4);
				bot_s5[k] <= lerp8(p_s4[2][CHW*k +: CHW], p_s4[3][CHW*k +: CHW], tx_s4);
			end
		end
	end

	// Stage 6: vertical lerp into the output register.
	logic [CHW-1:0] res_q [NCH];
	logic smp_q;

	always_ff @(posedge clk) begin
		if (adv6) begin
			smp_q <= (cmd_s5 == bwts_pkg::CMD_SAMPLE);
			for (int k = 0; k < NCH; k++) begin
				res_q[k] <= (cmd_s5 == bwts_pkg::CMD_SAMPLE) ? lerp8(top_s5[k], bot_s5[k], ty_s5) : '0;
			end
		end
	end

	assign out_valid  = v6_q;
	assign out_red    = res_q[0];
	assign out_green  = res_q[1];
	assign out_blue   = res_q[2];
	assign out_alpha  = res_q[3];
	assign was_sample = smp_q;

`ifndef SYNTHESIS
	a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re)) else $error("pixel memory read and written in one cycle");
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		v3_q |-> (phase_q <= bwts_pkg::PH_LAST)) else $error("fetch phase out of range");
	a_sample_leaves_last: assert property (@(posedge clk) disable iff (!arst_n)
		(done3 && take4 && cmd_s3 == bwts_pkg::CMD_SAMPLE) |-> (phase_q == bwts_pkg::PH_LAST))
		else $error("sample left fetch before all neighbours were read");
	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !was_sample) |-> (out_red == '0 && out_green == '0
		&& out_blue == '0 && out_alpha == '0)) else $error("write acknowledge carries data");
	a_read_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_re && !take3) |=> (phase_q == $past(phase_q) + 3'd1))
		else $error("fetch phase did not advance after a read");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the bilinear wrap texture sampler. Write and sample
// transactions are driven with random gaps and checked against a built-in
// model of the pixel store and the bilinear filter, under changing image sizes
// and random output stalls. Any pixel that a sample needs is written first.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       was_sample;
	} texel_result_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [bwts_pkg::APB_AW-1:0] paddr;
	logic [bwts_pkg::APB_DW-1:0] pwdata;
	logic [bwts_pkg::APB_DW-1:0] prdata;
	logic pready;
	logic in_valid, in_ready;
	logic command;
	logic signed [bwts_pkg::COORD_W-1:0] coord_x, coord_y;
	logic [7:0] write_red, write_green, write_blue, write_alpha;
	logic out_valid, out_ready;
	logic [7:0] out_red, out_green, out_blue, out_alpha;
	logic was_sample;

	logic [31:0] texel_mem [0:65535];
	bit texel_written [0:65535];
	logic [8:0] width_reg, height_reg;
	texel_result_t expected_texels[$];

	int burst_left, hold_off, stall_mode, stall_count;
	int n_writes, n_samples, n_checked, n_errors;

	bilinear_wrap_texture_sampler dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.coord_x(coord_x), .coord_y(coord_y),
		.write_red(write_red), .write_green(write_green),
		.write_blue(write_blue), .write_alpha(write_alpha),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue),
		.out_alpha(out_alpha), .was_sample(was_sample)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int eff_width();
		return (width_reg == 0) ? 1 : ((width_reg > 256) ? 256 : int'(width_reg));
	endfunction

	function automatic int eff_height();
		return (height_reg == 0) ? 1 : ((height_reg > 256) ? 256 : int'(height_reg));
	endfunction

	function automatic void wrap_taps(input int c, input int size, output int i0,
			output int i1, output int t);
		int period, rr;
		period = size * 256;
		rr = c % period;
		if (rr < 0) begin
			rr += period;
		end
		i0 = rr >> 8;
		t = rr & 255;
		i1 = (i0 == size - 1) ? 0 : i0 + 1;
	endfunction

	function automatic int lerp_channel(input int a, input int b, input int t);
		return ((a * (256 - t) + b * t) >> 8) & 255;
	endfunction

	function automatic texel_result_t predict_texel(input bwts_pkg::cmd_t cmd, input int x,
			input int y, input logic [31:0] rgba);
		texel_result_t res;
		int x0, x1, y0, y1, tx, ty, s, top, bot;
		logic [31:0] p00, p10, p01, p11;
		logic [7:0] ch [4];
		res = '0;
		if (cmd == bwts_pkg::CMD_WRITE) begin
			if (x >= 0 && y >= 0 && x < eff_width() && y < eff_height()) begin
				texel_mem[y * 256 + x] = rgba;
				texel_written[y * 256 + x] = 1'b1;
			end
			return res;
		end
		wrap_taps(x, eff_width(), x0, x1, tx);
		wrap_taps(y, eff_height(), y0, y1, ty);
		p00 = texel_mem[y0 * 256 + x0];
		p10 = texel_mem[y0 * 256 + x1];
		p01 = texel_mem[y1 * 256 + x0];
		p11 = texel_mem[y1 * 256 + x1];
		for (int k = 0; k < 4; k++) begin
			s = k * 8;
			top = lerp_channel((p00 >> s) & 255, (p10 >> s) & 255, tx);
			bot = lerp_channel((p01 >> s) & 255, (p11 >> s) & 255, tx);
			ch[k] = 8'(lerp_channel(top, bot, ty));
		end
		res.red = ch[0];
		res.green = ch[1];
		res.blue = ch[2];
		res.alpha = ch[3];
		res.was_sample = 1'b1;
		return res;
	endfunction

	task automatic send_item(input bwts_pkg::cmd_t cmd, input int x, input int y,
			input logic [31:0] rgba);
		int gap;
		@(negedge clk);
		in_valid = 1'b1;
		command = cmd;
		coord_x = (bwts_pkg::COORD_W)'(x);
		coord_y = (bwts_pkg::COORD_W)'(y);
		{write_alpha, write_blue, write_green, write_red} = rgba;
		do @(posedge clk); while (!in_ready);
		expected_texels.push_back(predict_texel(cmd, x, y, rgba));
		if (cmd == bwts_pkg::CMD_WRITE) n_writes++;
		else n_samples++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic fill_texel(input int x, input int y);
		if (!texel_written[y * 256 + x]) begin
			send_item(bwts_pkg::CMD_WRITE, x, y, $urandom());
		end
	endtask

	task automatic sample_at(input int x, input int y);
		int x0, x1, y0, y1, tx, ty;
		wrap_taps(x, eff_width(), x0, x1, tx);
		wrap_taps(y, eff_height(), y0, y1, ty);
		fill_texel(x0, y0);
		fill_texel(x1, y0);
		fill_texel(x0, y1);
		fill_texel(x1, y1);
		send_item(bwts_pkg::CMD_SAMPLE, x, y, $urandom());
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		wait (expected_texels.size() == 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_size(input logic reg_idx, input logic [8:0] value);
		wait_drained();
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {reg_idx, 2'b00};
		pwdata = {16'd0, 7'($urandom_range(0, 127)), value};
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if (reg_idx == bwts_pkg::REG_IMAGE_WIDTH) width_reg = value;
		else height_reg = value;
	endtask

	task automatic test_default_size();
		send_item(bwts_pkg::CMD_WRITE, 255, 255, 32'hFFFF_FFFF);
		send_item(bwts_pkg::CMD_WRITE, 0, 255, 32'h0000_0000);
		send_item(bwts_pkg::CMD_WRITE, 255, 0, 32'hFF00_FF00);
		send_item(bwts_pkg::CMD_WRITE, 0, 0, 32'h00FF_00FF);
		send_item(bwts_pkg::CMD_WRITE, -1, 3, 32'h1234_5678);
		send_item(bwts_pkg::CMD_WRITE, 256, 3, 32'h1234_5678);
		send_item(bwts_pkg::CMD_WRITE, 3, -131072, 32'h1234_5678);
		send_item(bwts_pkg::CMD_WRITE, 3, 131071, 32'h1234_5678);
		sample_at(255 * 256 + 128, 255 * 256 + 128);
		sample_at(-128, -1);
		sample_at(131071, 131071);
		sample_at(-65536, -65536);
		sample_at(-131072, 0);
		sample_at(0, 255 * 256);
	endtask

	task automatic test_size_extremes();
		set_size(bwts_pkg::REG_IMAGE_WIDTH, 9'd0);
		set_size(bwts_pkg::REG_IMAGE_HEIGHT, 9'd511);
		send_item(bwts_pkg::CMD_WRITE, 1, 0, $urandom());
		sample_at(1000, 77 * 256 + 200);
		sample_at(-5, 131071);
		set_size(bwts_pkg::REG_IMAGE_WIDTH, 9'd511);
		set_size(bwts_pkg::REG_IMAGE_HEIGHT, 9'd0);
		send_item(bwts_pkg::CMD_WRITE, 0, 1, $urandom());
		sample_at(131071, -77);
		sample_at(-65536, 50000);
		set_size(bwts_pkg::REG_IMAGE_WIDTH, 9'd1);
		set_size(bwts_pkg::REG_IMAGE_HEIGHT, 9'd1);
		sample_at(128, 128);
		set_size(bwts_pkg::REG_IMAGE_WIDTH, 9'd256);
		set_size(bwts_pkg::REG_IMAGE_HEIGHT, 9'd2);
		sample_at(255 * 256 + 255, 256 + 255);
	endtask

	task automatic test_random_traffic(input int n_items);
		int w, h, x, y, start, i;
		start = n_writes + n_samples;
		i = 0;
		while (n_writes + n_samples - start < n_items) begin
			if (i % 60 == 0) begin
				case ($urandom_range(0, 4))
					0: begin
						set_size(bwts_pkg::REG_IMAGE_WIDTH, 9'($urandom_range(200, 511)));
						set_size(bwts_pkg::REG_IMAGE_HEIGHT, 9'($urandom_range(0, 3)));
					end
					1: begin
						set_size(bwts_pkg::REG_IMAGE_WIDTH, 9'($urandom_range(0, 3)));
						set_size(bwts_pkg::REG_IMAGE_HEIGHT, 9'($urandom_range(200, 511)));
					end
					default: begin
						set_size(bwts_pkg::REG_IMAGE_WIDTH, 9'($urandom_range(1, 16)));
						set_size(bwts_pkg::REG_IMAGE_HEIGHT, 9'($urandom_range(1, 16)));
					end
				endcase
			end
			w = eff_width();
			h = eff_height();
			x = $urandom_range(0, 196607) - 65536;
			y = $urandom_range(0, 196607) - 65536;
			case ($urandom_range(0, 9))
				0: send_item(bwts_pkg::CMD_WRITE, $urandom_range(0, 262143) - 131072,
					$urandom_range(0, 262143) - 131072, $urandom());
				1, 2, 3: send_item(bwts_pkg::CMD_WRITE, $urandom_range(0, w - 1),
					$urandom_range(0, h - 1), $urandom());
				4: sample_at($urandom_range(0, w * 256 - 1), $urandom_range(0, h * 256 - 1));
				default: sample_at(x, y);
			endcase
			i++;
		end
	endtask

	task automatic test_output_backpressure();
		set_size(bwts_pkg::REG_IMAGE_WIDTH, 9'd8);
		set_size(bwts_pkg::REG_IMAGE_HEIGHT, 9'd8);
		hold_off = 300;
		burst_left = 100;
		for (int i = 0; i < 40; i++) begin
			if (i[0]) sample_at($urandom_range(0, 196607) - 65536, $urandom_range(0, 2047));
			else send_item(bwts_pkg::CMD_WRITE, $urandom_range(0, 7), $urandom_range(0, 7),
				$urandom());
		end
	endtask

	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else begin
			if (stall_count == 0) begin
				stall_mode <= $urandom_range(0, 2);
				stall_count <= $urandom_range(20, 150);
			end else begin
				stall_count <= stall_count - 1;
			end
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(0, 1);
				default: out_ready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		texel_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_texels.size() == 0) begin
				$error("Unexpected result transaction");
				n_errors++;
			end else begin
				want = expected_texels.pop_front();
				n_checked++;
				if (out_red !== want.red) begin
					$error("out_red: expected %0d, got %0d", want.red, out_red);
					n_errors++;
				end
				if (out_green !== want.green) begin
					$error("out_green: expected %0d, got %0d", want.green, out_green);
					n_errors++;
				end
				if (out_blue !== want.blue) begin
					$error("out_blue: expected %0d, got %0d", want.blue, out_blue);
					n_errors++;
				end
				if (out_alpha !== want.alpha) begin
					$error("out_alpha: expected %0d, got %0d", want.alpha, out_alpha);
					n_errors++;
				end
				if (was_sample !== want.was_sample) begin
					$error("was_sample: expected %0d, got %0d", want.was_sample, was_sample);
					n_errors++;
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		command = bwts_pkg::CMD_WRITE;
		coord_x = '0;
		coord_y = '0;
		{write_red, write_green, write_blue, write_alpha} = '0;
		out_ready = 1'b0;
		width_reg = 9'd256;
		height_reg = 9'd256;
		burst_left = 0;
		hold_off = 0;
		stall_mode = 0;
		stall_count = 0;
		n_writes = 0;
		n_samples = 0;
		n_checked = 0;
		n_errors = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_default_size();
		test_size_extremes();
		test_output_backpressure();
		test_random_traffic(500);
		wait_drained();
		if (expected_texels.size() != 0) begin
			$error("%0d expected results never arrived", expected_texels.size());
			n_errors++;
		end
		$display("Covered %0d write and %0d sample transactions, %0d results checked,",
			n_writes, n_samples, n_checked);
		$display("over default, extreme and random image sizes with output stalls.");
		if (n_errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/core/bwts_pkg.sv
rtl/core/bilinear_wrap_texture_sampler.sv
tb/sv/tb_top.sv
